### hdl/dwt_pkg.sv
// dwt_pkg: shared widths, register codes, reset values, types and the sine table
// for the svpwm dwell time calculator; used by every other file of the block
package dwt_pkg;

    localparam int PERIOD_W  = 14;
    localparam int MOD_W     = 15;
    localparam int DWELL_W   = 14;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int SECTOR_W  = 3;
    localparam int ANGLE_W   = 9;
    localparam int EDGE_W    = 15;
    localparam int EDGE_N    = 8;
    localparam int SINE_W    = 15;
    localparam int SIDX_W    = 7;
    localparam int MT_W      = MOD_W + PERIOD_W;
    localparam int PROD_W    = MT_W + SINE_W;
    localparam int RND_SHIFT = 30;
    localparam int RAW_W     = PROD_W + 1 - RND_SHIFT;
    localparam int ACC_W     = 17;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD,
        CFG_MOD_INDEX,
        CFG_MIN_DWELL,
        CFG_MAX_DWELL
    } t_cfg_idx;

    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 14'd3500;
    localparam logic [MOD_W-1:0]    MOD_INDEX_RST = 15'd22938;
    localparam logic [DWELL_W-1:0]  MIN_DWELL_RST = 14'd100;
    localparam logic [DWELL_W-1:0]  MAX_DWELL_RST = 14'd3000;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [MOD_W-1:0]    mod_index;
        logic [DWELL_W-1:0]  min_dwell;
        logic [DWELL_W-1:0]  max_dwell;
    } t_cfg;

    typedef struct packed {
        logic              even;
        logic              neg_a;
        logic [SIDX_W-1:0] idx_a;
        logic              neg_b;
        logic [SIDX_W-1:0] idx_b;
    } t_cls;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DWELL,
        BK_ZERO,
        BK_EDGE,
        BK_OUT
    } t_back_state;

    localparam logic [SINE_W-1:0] SINE_TAB [0:90] = '{
        15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
        15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
        15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
        15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
        15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
        15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
        15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
        15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622,
        15'd21063, 15'd21498, 15'd21926, 15'd22348, 15'd22763,
        15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730,
        15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510,
        15'd26842, 15'd27166, 15'd27482, 15'd27789, 15'd28088,
        15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
        15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
        15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499,
        15'd31651, 15'd31795, 15'd31928, 15'd32052, 15'd32166,
        15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32588,
        15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763,
        15'd32767
    };

endpackage

### hdl/dwt_in_if.sv
// dwt_in_if: input channel of the dwell time calculator (sector and angle)
// depends on dwt_pkg for field widths
interface dwt_in_if;
    logic                          valid;
    logic                          ready;
    logic [dwt_pkg::SECTOR_W-1:0]  sector;
    logic [dwt_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output sector, output angle, input ready);
    modport sink   (input valid, input sector, input angle, output ready);
endinterface

### hdl/dwt_out_if.sv
// dwt_out_if: result channel of the dwell time calculator (edge_one to edge_eight and flags)
// depends on dwt_pkg for field widths
interface dwt_out_if;
    logic                        valid;
    logic                        ready;
    logic [dwt_pkg::EDGE_W-1:0]  edge_one;
    logic [dwt_pkg::EDGE_W-1:0]  edge_two;
    logic [dwt_pkg::EDGE_W-1:0]  edge_three;
    logic [dwt_pkg::EDGE_W-1:0]  edge_four;
    logic [dwt_pkg::EDGE_W-1:0]  edge_five;
    logic [dwt_pkg::EDGE_W-1:0]  edge_six;
    logic [dwt_pkg::EDGE_W-1:0]  edge_seven;
    logic [dwt_pkg::EDGE_W-1:0]  edge_eight;
    logic                        even_sector;
    logic                        overmodulated;

    modport source (
        output valid, output edge_one, output edge_two, output edge_three,
        output edge_four, output edge_five, output edge_six, output edge_seven,
        output edge_eight, output even_sector, output overmodulated, input ready
    );
    modport sink (
        input valid, input edge_one, input edge_two, input edge_three,
        input edge_four, input edge_five, input edge_six, input edge_seven,
        input edge_eight, input even_sector, input overmodulated, output ready
    );
endinterface

### hdl/dwt_front.sv
// dwt_front: input stage, angle reduction and quadrant folding for both sine lookups
// depends on dwt_pkg and dwt_in_if; feeds the classified item queue
module dwt_front #(
    parameter int SINE_ENTRIES = 360
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dwt_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output dwt_pkg::t_cls   o_cls
);

    localparam int ANGLE_MAX = (1 << dwt_pkg::ANGLE_W) - 1;
    localparam int NSUB      = ANGLE_MAX / SINE_ENTRIES;
    localparam int RW        = dwt_pkg::ANGLE_W + 2;
    localparam logic [RW-1:0] SE_C     = RW'(SINE_ENTRIES);
    localparam logic [RW-1:0] DEG_360  = RW'(360);
    localparam logic [RW-1:0] DEG_420  = RW'(420);

    logic                             r_valid;
    logic [dwt_pkg::SECTOR_W-1:0]     r_sector;
    logic [dwt_pkg::ANGLE_W-1:0]      r_angle;
    logic [RW-1:0]                    w_red;
    logic [RW-1:0]                    w_comp;
    logic [dwt_pkg::ANGLE_W-1:0]      deg;
    logic [dwt_pkg::ANGLE_W-1:0]      comp;
    logic                             accept;

    function automatic logic [dwt_pkg::SIDX_W:0] fold(input logic [dwt_pkg::ANGLE_W-1:0] d);
        logic                         neg;
        logic [dwt_pkg::ANGLE_W-1:0]  m;
        neg = 1'b0;
        m   = d;
        priority if (d <= 9'd90) begin
            neg = 1'b0;
            m   = d;
        end else if (d <= 9'd180) begin
            neg = 1'b0;
            m   = 9'd180 - d;
        end else if (d <= 9'd270) begin
            neg = 1'b1;
            m   = d - 9'd180;
        end else begin
            neg = 1'b1;
            m   = 9'd360 - d;
        end
        return {neg, m[dwt_pkg::SIDX_W-1:0]};
    endfunction

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_valid || !i_full;
    assign o_push      = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sector <= i_in.sector;
            r_angle  <= i_in.angle;
        end
    end

    // angle mod table length, then mod 360, then the complementary angle
    always_comb begin
        w_red = RW'(r_angle);
        for (int k = 0; k < NSUB; k++) begin
            if (w_red >= SE_C) begin
                w_red = w_red - SE_C;
            end
        end
        if (w_red >= DEG_360) begin
            w_red = w_red - DEG_360;
        end
        deg    = w_red[dwt_pkg::ANGLE_W-1:0];
        w_comp = DEG_420 - RW'(deg);
        if (w_comp >= DEG_360) begin
            w_comp = w_comp - DEG_360;
        end
        comp = w_comp[dwt_pkg::ANGLE_W-1:0];
    end

    always_comb begin
        o_cls                       = '0;
        o_cls.even                  = !r_sector[0];
        {o_cls.neg_b, o_cls.idx_b}  = fold(deg);
        {o_cls.neg_a, o_cls.idx_a}  = fold(comp);
    end

endmodule

### hdl/dwt_fifo.sv
// dwt_fifo: short queue of classified items between the front and back parts
// depends on dwt_pkg for the item type and depth
module dwt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dwt_pkg::t_cls   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output dwt_pkg::t_cls   o_data,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(dwt_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(dwt_pkg::FIFO_DEPTH + 1);

    dwt_pkg::t_cls    r_mem [dwt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(dwt_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hdl/dwt_back.sv
// dwt_back: sequencer that turns a queued item into dwell times, zero time and edges
// depends on dwt_pkg (sine table, types) and dwt_out_if; holds the result register
module dwt_back #(
    parameter int TIME_WIDTH = 15
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dwt_pkg::t_cfg   i_cfg,
    input  logic            i_empty,
    input  dwt_pkg::t_cls   i_cls,
    output logic            o_pop,
    dwt_out_if.source       o_out
);

    localparam int ACC_W  = dwt_pkg::ACC_W;
    localparam int EW     = dwt_pkg::EDGE_W;
    localparam int DW     = dwt_pkg::DWELL_W;
    localparam int IDX_W  = $clog2(dwt_pkg::EDGE_N);
    localparam logic [ACC_W-1:0] EDGE_MAX = ACC_W'((1 << TIME_WIDTH) - 1);
    localparam logic [dwt_pkg::PROD_W:0] ROUND_C = (dwt_pkg::PROD_W + 1)'(1) <<
                                                   (dwt_pkg::RND_SHIFT - 1);

    dwt_pkg::t_back_state          r_state;
    dwt_pkg::t_back_state          n_state;
    logic [dwt_pkg::MT_W-1:0]      r_mt;
    logic [dwt_pkg::SINE_W-1:0]    r_sa;
    logic [dwt_pkg::SINE_W-1:0]    r_sb;
    logic [dwt_pkg::PROD_W-1:0]    r_pa;
    logic [dwt_pkg::PROD_W-1:0]    r_pb;
    logic                          r_even;
    logic [DW-1:0]                 r_ta;
    logic [DW-1:0]                 r_tb;
    logic [DW-1:0]                 r_t0;
    logic                          r_over;
    logic [ACC_W-1:0]              r_acc;
    logic [IDX_W-1:0]              r_idx;
    logic [EW-1:0]                 r_edge [dwt_pkg::EDGE_N];
    logic                          r_ovalid;
    logic [EW-1:0]                 r_oedge [dwt_pkg::EDGE_N];
    logic                          r_oeven;
    logic                          r_oover;
    logic                          load_out;
    logic                          out_free;
    logic [DW-1:0]                 da;
    logic [DW-1:0]                 db;
    logic [DW:0]                   tsum;
    logic                          over;
    logic [DW:0]                   t0_full;
    logic [ACC_W-1:0]              addend;
    logic [ACC_W-1:0]              acc_n;
    logic [ACC_W-1:0]              acc_sat;

    function automatic logic [DW-1:0] to_dwell(
        input logic [dwt_pkg::PROD_W-1:0] p,
        input logic [DW-1:0]              lo,
        input logic [DW-1:0]              hi
    );
        logic [dwt_pkg::PROD_W:0]    s;
        logic [dwt_pkg::RAW_W-1:0]   raw;
        s   = (dwt_pkg::PROD_W + 1)'(p) + ROUND_C;
        raw = s[dwt_pkg::PROD_W:dwt_pkg::RND_SHIFT];
        if (raw < dwt_pkg::RAW_W'(lo)) begin
            raw = dwt_pkg::RAW_W'(lo);
        end
        if (raw > dwt_pkg::RAW_W'(hi)) begin
            raw = dwt_pkg::RAW_W'(hi);
        end
        return raw[DW-1:0];
    endfunction

    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwt_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            dwt_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = dwt_pkg::BK_MUL;
                end
            end
            dwt_pkg::BK_MUL:   n_state = dwt_pkg::BK_DWELL;
            dwt_pkg::BK_DWELL: n_state = dwt_pkg::BK_ZERO;
            dwt_pkg::BK_ZERO:  n_state = dwt_pkg::BK_EDGE;
            dwt_pkg::BK_EDGE: begin
                if (r_idx == IDX_W'(dwt_pkg::EDGE_N - 1)) begin
                    n_state = dwt_pkg::BK_OUT;
                end
            end
            dwt_pkg::BK_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = dwt_pkg::BK_IDLE;
                end
            end
            default: n_state = dwt_pkg::BK_IDLE;
        endcase
    end

    // dwell clamp and zero time
    always_comb begin
        da      = to_dwell(r_pa, i_cfg.min_dwell, i_cfg.max_dwell);
        db      = to_dwell(r_pb, i_cfg.min_dwell, i_cfg.max_dwell);
        tsum    = (DW + 1)'(r_ta) + (DW + 1)'(r_tb);
        over    = tsum > (DW + 1)'(i_cfg.period);
        t0_full = (DW + 1)'(i_cfg.period) - tsum;
    end

    // quarter and half fractions in edge order
    always_comb begin
        unique case (r_idx)
            3'd0:    addend = ACC_W'(r_ta >> 2);
            3'd4:    addend = ACC_W'(r_ta >> 1);
            3'd2,
            3'd6:    addend = ACC_W'(r_t0 >> 1);
            default: addend = ACC_W'(r_tb >> 2);
        endcase
        acc_n   = r_acc + addend;
        acc_sat = (acc_n > EDGE_MAX) ? EDGE_MAX : acc_n;
    end

    always_ff @(posedge i_clk) begin
        r_mt <= dwt_pkg::MT_W'(i_cfg.mod_index) * dwt_pkg::MT_W'(i_cfg.period);
        unique case (r_state)
            dwt_pkg::BK_IDLE: begin
                r_sa   <= i_cls.neg_a ? '0 : dwt_pkg::SINE_TAB[i_cls.idx_a];
                r_sb   <= i_cls.neg_b ? '0 : dwt_pkg::SINE_TAB[i_cls.idx_b];
                r_even <= i_cls.even;
            end
            dwt_pkg::BK_MUL: begin
                r_pa <= dwt_pkg::PROD_W'(r_mt) * dwt_pkg::PROD_W'(r_sa);
                r_pb <= dwt_pkg::PROD_W'(r_mt) * dwt_pkg::PROD_W'(r_sb);
            end
            dwt_pkg::BK_DWELL: begin
                r_ta <= r_even ? db : da;
                r_tb <= r_even ? da : db;
            end
            dwt_pkg::BK_ZERO: begin
                r_t0   <= over ? '0 : t0_full[DW-1:0];
                r_over <= over;
                r_acc  <= '0;
                r_idx  <= '0;
            end
            dwt_pkg::BK_EDGE: begin
                r_acc         <= acc_n;
                r_edge[r_idx] <= acc_sat[EW-1:0];
                r_idx         <= r_idx + 1'b1;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_oedge <= r_edge;
            r_oeven <= r_even;
            r_oover <= r_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.edge_one      = r_oedge[0];
    assign o_out.edge_two      = r_oedge[1];
    assign o_out.edge_three    = r_oedge[2];
    assign o_out.edge_four     = r_oedge[3];
    assign o_out.edge_five     = r_oedge[4];
    assign o_out.edge_six      = r_oedge[5];
    assign o_out.edge_seven    = r_oedge[6];
    assign o_out.edge_eight    = r_oedge[7];
    assign o_out.even_sector   = r_oeven;
    assign o_out.overmodulated = r_oover;

endmodule

### hdl/svpwm_dwell_time_calc_unit.sv
// svpwm_dwell_time_calc_unit: top level, configuration registers, front, queue, back
// an input passes the front register, the queue, then back states IDLE, MUL, DWELL, ZERO, EDGE, OUT
// the back sequencer works on one item at a time, accumulating its edges in order, and pops the next
// only from idle; the front keeps taking transfers into a 4-entry queue while the back is busy
// reset: queue and result register empty, registers at 3500, 22938, 100, 3000
// depends on dwt_pkg, dwt_in_if, dwt_out_if, dwt_front, dwt_fifo, dwt_back
module svpwm_dwell_time_calc_unit #(
    parameter int TIME_WIDTH   = 15,
    parameter int SINE_ENTRIES = 360
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dwt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dwt_pkg::CFG_W-1:0]       i_cfg_data,
    dwt_in_if.sink                          i_in,
    dwt_out_if.source                       o_out
);

    dwt_pkg::t_cfg  r_cfg;
    dwt_pkg::t_cls  front_cls;
    dwt_pkg::t_cls  fifo_cls;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period    <= dwt_pkg::PERIOD_RST;
            r_cfg.mod_index <= dwt_pkg::MOD_INDEX_RST;
            r_cfg.min_dwell <= dwt_pkg::MIN_DWELL_RST;
            r_cfg.max_dwell <= dwt_pkg::MAX_DWELL_RST;
        end else if (i_cfg_we) begin
            unique case (dwt_pkg::t_cfg_idx'(i_cfg_idx))
                dwt_pkg::CFG_PERIOD:    r_cfg.period    <= i_cfg_data[dwt_pkg::PERIOD_W-1:0];
                dwt_pkg::CFG_MOD_INDEX: r_cfg.mod_index <= i_cfg_data[dwt_pkg::MOD_W-1:0];
                dwt_pkg::CFG_MIN_DWELL: r_cfg.min_dwell <= i_cfg_data[dwt_pkg::DWELL_W-1:0];
                dwt_pkg::CFG_MAX_DWELL: r_cfg.max_dwell <= i_cfg_data[dwt_pkg::DWELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dwt_front #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cls   (front_cls)
    );

    dwt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (fifo_cls),
        .o_empty (empty)
    );

    dwt_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_cls   (fifo_cls),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### tb/sv/svpwm_dwell_time_calc_unit_test.sv
// svpwm_dwell_time_calc_unit_test: self-checking bench for the svpwm dwell time calculator
// a directed table, then random sector/angle traffic over several register settings, checked
// against an in-bench edge predictor; depends on dwt_pkg, dwt_in_if, dwt_out_if and the rtl
module svpwm_dwell_time_calc_unit_test;

    localparam int     TIME_WIDTH   = 15;
    localparam int     SINE_ENTRIES = 360;
    localparam longint EDGE_LIMIT   = (longint'(1) << TIME_WIDTH) - 1;
    localparam int     STALL_LIMIT  = 3000;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_ITEMS  = 228;
    localparam int     DIR_ROWS     = 23;

    typedef struct packed {
        logic [0:dwt_pkg::EDGE_N-1][dwt_pkg::EDGE_W-1:0] edges;
        logic                                            even_sector;
        logic                                            overmodulated;
    } t_edge_set;

    typedef struct packed {
        logic [2:0]                   phase;
        logic [dwt_pkg::SECTOR_W-1:0] sector;
        logic [dwt_pkg::ANGLE_W-1:0]  angle;
        logic                         typed;
        t_edge_set                    lit;
    } t_stim_row;

    localparam int unsigned QUARTER_WAVE [0:90] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32767
    };

    // zero modulation: both dwells sit on min_dwell = 100 with period 3500
    localparam logic [0:dwt_pkg::EDGE_N-1][dwt_pkg::EDGE_W-1:0] MIN_ONLY_EDGES = '{
        15'd25, 15'd50, 15'd1700, 15'd1725, 15'd1775, 15'd1800, 15'd3450, 15'd3475
    };
    // min above max: both dwells at max_dwell = 2000, zero time saturated
    localparam logic [0:dwt_pkg::EDGE_N-1][dwt_pkg::EDGE_W-1:0] CROSSED_EDGES = '{
        15'd500, 15'd1000, 15'd1000, 15'd1500, 15'd2500, 15'd3000, 15'd3000, 15'd3500
    };

    localparam dwt_pkg::t_cfg DIR_CFG [0:4] = '{
        '{dwt_pkg::PERIOD_RST, dwt_pkg::MOD_INDEX_RST, dwt_pkg::MIN_DWELL_RST,
          dwt_pkg::MAX_DWELL_RST},
        '{14'd3500, 15'd0, 14'd100, 14'd3000},
        '{14'd3500, 15'd22938, 14'd16383, 14'd2000},
        '{14'd16383, 15'd32767, 14'd0, 14'd16383},
        '{14'd200, 15'd32767, 14'd0, 14'd16383}
    };

    localparam t_stim_row DIR_STIM [0:DIR_ROWS-1] = '{
        '{3'd0, 3'd1, 9'd0, 1'b0, '0},
        '{3'd0, 3'd2, 9'd30, 1'b0, '0},
        '{3'd0, 3'd3, 9'd59, 1'b0, '0},
        '{3'd0, 3'd4, 9'd60, 1'b0, '0},
        '{3'd0, 3'd5, 9'd90, 1'b0, '0},
        '{3'd0, 3'd6, 9'd45, 1'b0, '0},
        '{3'd0, 3'd0, 9'd180, 1'b0, '0},
        '{3'd0, 3'd7, 9'd270, 1'b0, '0},
        '{3'd0, 3'd1, 9'd300, 1'b0, '0},
        '{3'd0, 3'd2, 9'd359, 1'b0, '0},
        '{3'd0, 3'd3, 9'd360, 1'b0, '0},
        '{3'd0, 3'd5, 9'd420, 1'b0, '0},
        '{3'd0, 3'd4, 9'd511, 1'b0, '0},
        '{3'd1, 3'd1, 9'd0, 1'b1, '{MIN_ONLY_EDGES, 1'b0, 1'b0}},
        '{3'd1, 3'd2, 9'd45, 1'b1, '{MIN_ONLY_EDGES, 1'b1, 1'b0}},
        '{3'd2, 3'd3, 9'd20, 1'b1, '{CROSSED_EDGES, 1'b0, 1'b1}},
        '{3'd2, 3'd0, 9'd511, 1'b1, '{CROSSED_EDGES, 1'b1, 1'b1}},
        '{3'd3, 3'd1, 9'd30, 1'b0, '0},
        '{3'd3, 3'd6, 9'd0, 1'b0, '0},
        '{3'd3, 3'd5, 9'd200, 1'b0, '0},
        '{3'd3, 3'd4, 9'd90, 1'b0, '0},
        '{3'd4, 3'd1, 9'd15, 1'b0, '0},
        '{3'd4, 3'd2, 9'd59, 1'b0, '0}
    };

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        cfg_we;
    dwt_pkg::t_cfg_idx           cfg_idx;
    logic [dwt_pkg::CFG_W-1:0]   cfg_data;
    dwt_pkg::t_cfg               shadow;
    t_edge_set                   pending_edge_sets [$];
    int                          mismatch_count = 0;
    int                          idle_cycles = 0;
    logic                        send_calm = 1'b0;
    logic                        hold_req = 1'b0;

    dwt_in_if  in_ch ();
    dwt_out_if out_ch ();

    svpwm_dwell_time_calc_unit #(
        .TIME_WIDTH   (TIME_WIDTH),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int sine_q15_deg(input int unsigned d);
        d = d % 360;
        if (d <= 90) return QUARTER_WAVE[d];
        if (d <= 180) return QUARTER_WAVE[180 - d];
        if (d <= 270) return -int'(QUARTER_WAVE[d - 180]);
        return -int'(QUARTER_WAVE[360 - d]);
    endfunction

    function automatic longint dwell_counts(input int s);
        longint raw;
        raw = 0;
        if (s > 0) begin
            raw = (longint'(shadow.mod_index) * longint'(shadow.period) * longint'(s)
                   + (longint'(1) << 29)) >>> 30;
        end
        if (raw < longint'(shadow.min_dwell)) raw = longint'(shadow.min_dwell);
        if (raw > longint'(shadow.max_dwell)) raw = longint'(shadow.max_dwell);
        return raw;
    endfunction

    function automatic t_edge_set predict_edge_set(input logic [dwt_pkg::SECTOR_W-1:0] sec,
                                                   input logic [dwt_pkg::ANGLE_W-1:0] ang);
        t_edge_set   r;
        int unsigned deg;
        int unsigned comp;
        longint      ta;
        longint      tb;
        longint      t0;
        longint      swap;
        longint      acc [0:dwt_pkg::EDGE_N-1];
        deg  = (int'(ang) % SINE_ENTRIES) % 360;
        comp = (420 - deg) % 360;
        tb   = dwell_counts(sine_q15_deg(deg));
        ta   = dwell_counts(sine_q15_deg(comp));
        r.even_sector = ~sec[0];
        if (r.even_sector) begin
            swap = ta;
            ta   = tb;
            tb   = swap;
        end
        t0 = longint'(shadow.period) - ta - tb;
        r.overmodulated = (t0 < 0);
        if (t0 < 0) t0 = 0;
        acc[0] = ta / 4;
        acc[1] = acc[0] + tb / 4;
        acc[2] = acc[1] + t0 / 2;
        acc[3] = acc[2] + tb / 4;
        acc[4] = acc[3] + ta / 2;
        acc[5] = acc[4] + tb / 4;
        acc[6] = acc[5] + t0 / 2;
        acc[7] = acc[6] + tb / 4;
        for (int k = 0; k < dwt_pkg::EDGE_N; k++) begin
            r.edges[k] = (acc[k] > EDGE_LIMIT) ? dwt_pkg::EDGE_W'(EDGE_LIMIT)
                                               : dwt_pkg::EDGE_W'(acc[k]);
        end
        return r;
    endfunction

    task automatic apply_setting(input dwt_pkg::t_cfg s);
        dwt_pkg::t_cfg_idx          ix;
        logic [dwt_pkg::CFG_W-1:0]  word;
        logic                       noise;
        for (int r = 0; r < 4; r++) begin
            ix    = dwt_pkg::t_cfg_idx'(r);
            noise = 1'($urandom_range(0, 1));
            unique case (ix)
                dwt_pkg::CFG_PERIOD:    word = {noise, s.period};
                dwt_pkg::CFG_MOD_INDEX: word = s.mod_index;
                dwt_pkg::CFG_MIN_DWELL: word = {noise, s.min_dwell};
                dwt_pkg::CFG_MAX_DWELL: word = {noise, s.max_dwell};
            endcase
            cfg_we   <= 1'b1;
            cfg_idx  <= ix;
            cfg_data <= word;
            @(posedge clk);
            unique case (ix)
                dwt_pkg::CFG_PERIOD:    shadow.period    = word[dwt_pkg::PERIOD_W-1:0];
                dwt_pkg::CFG_MOD_INDEX: shadow.mod_index = word[dwt_pkg::MOD_W-1:0];
                dwt_pkg::CFG_MIN_DWELL: shadow.min_dwell = word[dwt_pkg::DWELL_W-1:0];
                dwt_pkg::CFG_MAX_DWELL: shadow.max_dwell = word[dwt_pkg::DWELL_W-1:0];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results;
        in_ch.valid <= 1'b0;
        while (pending_edge_sets.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic send_item(input logic [dwt_pkg::SECTOR_W-1:0] sec,
                             input logic [dwt_pkg::ANGLE_W-1:0] ang,
                             input logic typed, input t_edge_set lit);
        int unsigned gap;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sector <= sec;
        in_ch.angle  <= ang;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        pending_edge_sets.push_back(typed ? lit : predict_edge_set(sec, ang));
    endtask

    task automatic check_edge_set(input t_edge_set got);
        t_edge_set want;
        if (pending_edge_sets.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing pending, edge_one %0d", $time, got.edges[0]);
        end else begin
            want = pending_edge_sets.pop_front();
            for (int k = 0; k < dwt_pkg::EDGE_N; k++) begin
                if (got.edges[k] !== want.edges[k]) begin
                    mismatch_count++;
                    $display("%0t: edge %0d expected %0d got %0d", $time, k + 1,
                             want.edges[k], got.edges[k]);
                end
            end
            if (got.even_sector !== want.even_sector) begin
                mismatch_count++;
                $display("%0t: even_sector expected %0b got %0b", $time,
                         want.even_sector, got.even_sector);
            end
            if (got.overmodulated !== want.overmodulated) begin
                mismatch_count++;
                $display("%0t: overmodulated expected %0b got %0b", $time,
                         want.overmodulated, got.overmodulated);
            end
        end
    endtask

    // result side with random stalls and one long hold-off on request
    initial begin : result_side
        t_edge_set   got;
        int unsigned stall;
        int unsigned taken;
        logic        recv_calm;
        logic        hold_done;
        out_ch.ready <= 1'b0;
        taken     = 0;
        recv_calm = 1'b0;
        hold_done = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (taken % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
            stall = recv_calm ? 0 : $urandom_range(0, 7);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (out_ch.valid !== 1'b1) @(posedge clk);
            got.edges[0]      = out_ch.edge_one;
            got.edges[1]      = out_ch.edge_two;
            got.edges[2]      = out_ch.edge_three;
            got.edges[3]      = out_ch.edge_four;
            got.edges[4]      = out_ch.edge_five;
            got.edges[5]      = out_ch.edge_six;
            got.edges[6]      = out_ch.edge_seven;
            got.edges[7]      = out_ch.edge_eight;
            got.even_sector   = out_ch.even_sector;
            got.overmodulated = out_ch.overmodulated;
            taken++;
            check_edge_set(got);
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("svpwm_dwell_time_calc_unit_test: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        dwt_pkg::t_cfg                s;
        logic [dwt_pkg::SECTOR_W-1:0] sec;
        logic [dwt_pkg::ANGLE_W-1:0]  ang;
        logic [2:0]                   cur_phase;
        in_ch.valid  <= 1'b0;
        in_ch.sector <= '0;
        in_ch.angle  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= dwt_pkg::CFG_PERIOD;
        cfg_data     <= '0;
        shadow       = DIR_CFG[0];
        cur_phase    = 3'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_STIM[i].phase != cur_phase) begin
                drain_results();
                cur_phase = DIR_STIM[i].phase;
                apply_setting(DIR_CFG[cur_phase]);
            end
            send_item(DIR_STIM[i].sector, DIR_STIM[i].angle, DIR_STIM[i].typed,
                      DIR_STIM[i].lit);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: s = DIR_CFG[0];
                1: s = '{14'd16383, 15'd32767, 14'd0, 14'd16383};
                2: begin
                    s = '{14'd200, 15'd0, 14'd0, 14'd200};
                    s.mod_index = dwt_pkg::MOD_W'($urandom_range(0, 32767));
                end
                3: begin
                    // lower clamp above upper clamp
                    s.period    = dwt_pkg::PERIOD_W'($urandom_range(200, 16383));
                    s.mod_index = dwt_pkg::MOD_W'($urandom_range(0, 32767));
                    s.min_dwell = dwt_pkg::DWELL_W'($urandom_range(2000, 16383));
                    s.max_dwell = dwt_pkg::DWELL_W'($urandom_range(0, 1999));
                end
                default: begin
                    s.period    = dwt_pkg::PERIOD_W'($urandom_range(200, 16383));
                    s.mod_index = dwt_pkg::MOD_W'($urandom_range(0, 32767));
                    s.min_dwell = dwt_pkg::DWELL_W'($urandom_range(0, s.period / 8));
                    s.max_dwell = dwt_pkg::DWELL_W'($urandom_range(s.period / 4, 16383));
                end
            endcase
            apply_setting(s);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 57 == 0) send_calm = ($urandom_range(0, 3) == 0);
                if (ph == 2 && n == 40) hold_req = 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    sec = dwt_pkg::SECTOR_W'($urandom_range(0, 7));
                end else begin
                    sec = dwt_pkg::SECTOR_W'($urandom_range(1, 6));
                end
                if ($urandom_range(0, 3) != 0) begin
                    ang = dwt_pkg::ANGLE_W'($urandom_range(0, 59));
                end else begin
                    ang = dwt_pkg::ANGLE_W'($urandom_range(0, 511));
                end
                send_item(sec, ang, 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_edge_sets.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("svpwm_dwell_time_calc_unit_test: done, clean");
        end else begin
            $display("svpwm_dwell_time_calc_unit_test: done, errors");
        end
        $finish;
    end

endmodule

### files.f
hdl/dwt_pkg.sv
hdl/dwt_in_if.sv
hdl/dwt_out_if.sv
hdl/dwt_front.sv
hdl/dwt_fifo.sv
hdl/dwt_back.sv
hdl/svpwm_dwell_time_calc_unit.sv
tb/sv/svpwm_dwell_time_calc_unit_test.sv
